// ----- hw/rtl/tsrh_pkg.sv -----
// Shared types, constants and helper functions for the tapped shift register.
`default_nettype none

package tsrh_pkg;

    // Default sizes for the top-level parameters
    localparam int NUM_STAGES_DEF   = 16;
    localparam int NUM_TAPS_DEF     = 8;
    localparam int SAMPLE_WIDTH_DEF = 16;

    // Fixed field widths
    localparam int MAX_TAPS   = 8;
    localparam int TAP_IDX_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int SPAN_W     = 8;
    localparam int STAGE_SEL_W = 4;
    localparam int MIX_W      = 9;
    localparam int DIV_W      = 8;
    localparam int CHANCE_W   = 7;
    localparam int TICK_W     = 16;

    // Feedback mix in Q1.8
    localparam int MIX_ONE   = 256;
    localparam int MIX_SHIFT = 8;

    // Random holds: percentage scale and LFSR seed
    localparam int                HOLD_SCALE = 100;
    localparam logic [TICK_W-1:0] LFSR_SEED  = 16'hACE1;

    // Remainder lanes retire this many dividend bits per cycle
    localparam int REM_BITS_PER_STEP = 4;

    // Reset values of the configuration registers
    localparam logic [SPAN_W-1:0]         SPAN_RST         = 8'd1;
    localparam logic [STAGE_SEL_W-1:0]    FEED_OUT_RST     = 4'd7;
    localparam logic [MAX_TAPS*DIV_W-1:0] TAP_DIVIDERS_RST = 64'h0101_0101_0101_0101;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPAN,
        CFG_SPAN_MODE,
        CFG_HOLD_MODE,
        CFG_FEED_IN,
        CFG_FEED_OUT,
        CFG_FEED_MIX,
        CFG_TAP_DIVIDERS,
        CFG_HOLD_CHANCES
    } cfg_reg_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_MIX,
        ST_WRITE,
        ST_TAP_RD,
        ST_TAP_OUT
    } tsrh_state_t;

    // Command from the sequencer to the hold unit
    typedef struct packed {
        logic start;
        logic random;
    } hold_ctl_t;

    // One step of the 16-bit Fibonacci LFSR, shifting right
    function automatic logic [TICK_W-1:0] lfsr_next(input logic [TICK_W-1:0] r);
        logic b;
        b = r[0] ^ r[2] ^ r[3] ^ r[5];
        return {b, r[TICK_W-1:1]};
    endfunction

    // Reduce an 8-bit value modulo n (1..256) by restoring subtraction
    function automatic logic [8:0] reduce_mod(input logic [7:0] x, input logic [8:0] n);
        logic [16:0] r;
        logic [16:0] nk;
        r = {9'd0, x};
        for (int k = 7; k >= 0; k--)
        begin
            nk = {8'd0, n} << k;
            if (r >= nk)
            begin
                r = r - nk;
            end
        end
        return r[8:0];
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tapped_shift_register_with_holds.sv -----
// Top level: stage chain in RAM, feedback mix, tap sequencing and config registers.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_ready    sample_in
// output    out        out_valid / out_ready  tap_index, tap_value, tap_held, last_tap
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// When the output side is ready, a sample passes through the feedback
// read-modify-write on the stage RAM (states IDLE, FEED, MIX and WRITE),
// a wait for the hold lanes, one tap read, then one tap transfer per cycle
// through the single RAM read port. Output stalls stretch the tap phase.
// Reset clears the stage valid bits, so the chain reads as zero without a
// clearing pass. in_ready drops for one cycle after each config write and
// for the first cycle after reset.
`default_nettype none

module tapped_shift_register_with_holds
    import tsrh_pkg::*;
#(
    parameter int NUM_STAGES   = NUM_STAGES_DEF,
    parameter int NUM_TAPS     = NUM_TAPS_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample_in,

    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic             [TAP_IDX_W-1:0]    tap_index,
    output logic signed      [SAMPLE_WIDTH-1:0] tap_value,
    output logic                                tap_held,
    output logic                                last_tap,

    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic        [CFG_IDX_W-1:0]    cfg_index,
    input  wire logic        [CFG_DATA_W-1:0]   cfg_data
);

    localparam int              W     = SAMPLE_WIDTH;
    localparam int              AW    = $clog2(NUM_STAGES);
    localparam int              TW    = (NUM_TAPS > 1) ? $clog2(NUM_TAPS) : 1;
    localparam logic [8:0]      N9    = 9'(NUM_STAGES);
    localparam logic [AW:0]     N_EXT = (AW+1)'(NUM_STAGES);
    localparam logic [AW-1:0]   LAST_STAGE = AW'(NUM_STAGES - 1);

    // Configuration registers
    logic [SPAN_W-1:0]            span_reg;
    logic                         span_mode_reg;
    logic                         hold_mode_reg;
    logic [STAGE_SEL_W-1:0]       feed_in_reg;
    logic [STAGE_SEL_W-1:0]       feed_out_reg;
    logic [MIX_W-1:0]             feed_mix_reg;
    logic [MAX_TAPS*DIV_W-1:0]    tap_dividers_reg;
    logic [MAX_TAPS*CHANCE_W-1:0] hold_chances_reg;
    logic                         cfg_settle_reg;

    // Config values reduced modulo the chain length
    logic [8:0]    span_mod;
    logic [8:0]    fi_mod;
    logic [8:0]    fo_mod;
    logic [AW-1:0] span_red_reg;
    logic [AW-1:0] fi_red_reg;
    logic [AW-1:0] fo_red_reg;

    // Sequencer and chain state
    tsrh_state_t           state_reg;
    tsrh_state_t           state_next;
    logic [AW-1:0]         wp_reg;
    logic [AW-1:0]         wp_inc;
    logic [NUM_STAGES-1:0] valid_reg;
    logic                  rd_valid_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [TW-1:0]         tap_idx_reg;
    logic [W-1:0]          tap_vals_reg [NUM_TAPS];

    // Datapath registers
    logic signed [W-1:0]  sample_reg;
    logic signed [W-1:0]  fb_reg;
    logic signed [W+9:0]  prod_old_reg;
    logic signed [W+9:0]  prod_fb_reg;
    logic [AW-1:0]        fi_addr_reg;
    logic                 fi_zero_reg;
    logic [AW-1:0]        loc_reg;

    // Output register
    logic                  out_valid_reg;
    logic [TAP_IDX_W-1:0]  out_idx_reg;
    logic [W-1:0]          out_value_reg;
    logic                  out_held_reg;
    logic                  out_last_reg;

    // RAM port
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [W-1:0]  ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [W-1:0]  ram_rd_data;

    // Hold unit
    hold_ctl_t             hold_ctl;
    logic [NUM_TAPS-1:0]   held_vec;
    logic                  hold_done;

    // Sequencer strobes
    logic take_item;
    logic fb_cap;
    logic mix_cap;
    logic taps_init;
    logic tap_load;

    // Combinational helpers
    logic signed [W-1:0]  stage_rd;
    logic signed [W-1:0]  old_val;
    logic [MIX_W-1:0]     mix_sat;
    logic [MIX_W-1:0]     mix_inv;
    logic signed [W+10:0] mix_sum;
    logic signed [W+10:0] mix_shift;
    logic [AW-1:0]        loc_start;
    logic [AW-1:0]        loc_step;
    logic [AW:0]          loc_sum;
    logic [AW-1:0]        loc_next;
    logic                 tap_last;
    logic                 tap_is_held;
    logic                 out_free;

    // Physical entry holding stage k when stage 0 sits at base
    function automatic logic [AW-1:0] stage_addr(input logic [AW-1:0] base,
                                                 input logic [AW-1:0] k);
        logic [AW:0] sum;
        if (base >= k)
        begin
            sum = {1'b0, base} - {1'b0, k};
        end
        else
        begin
            sum = {1'b0, base} + N_EXT - {1'b0, k};
        end
        return sum[AW-1:0];
    endfunction

    tsrh_ram #(
        .WIDTH (W),
        .DEPTH (NUM_STAGES)
    ) u_stage_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    tsrh_hold #(
        .NUM_TAPS (NUM_TAPS)
    ) u_hold (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (hold_ctl),
        .tick     (tick_reg),
        .dividers (tap_dividers_reg),
        .chances  (hold_chances_reg),
        .held     (held_vec),
        .done     (hold_done)
    );

    // Reduce config selectors to stage numbers
    assign span_mod = reduce_mod(span_reg, N9);
    assign fi_mod   = reduce_mod({4'd0, feed_in_reg}, N9);
    assign fo_mod   = reduce_mod({4'd0, feed_out_reg}, N9);

    always_ff @(posedge clk)
    begin
        span_red_reg <= span_mod[AW-1:0];
        fi_red_reg   <= fi_mod[AW-1:0];
        fo_red_reg   <= fo_mod[AW-1:0];
    end

    // Configuration writes
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg         <= SPAN_RST;
            span_mode_reg    <= 1'b0;
            hold_mode_reg    <= 1'b0;
            feed_in_reg      <= '0;
            feed_out_reg     <= FEED_OUT_RST;
            feed_mix_reg     <= '0;
            tap_dividers_reg <= TAP_DIVIDERS_RST;
            hold_chances_reg <= '0;
            cfg_settle_reg   <= 1'b1;
        end
        else
        begin
            cfg_settle_reg <= cfg_valid;
            if (cfg_valid)
            begin
                unique case (cfg_reg_t'(cfg_index))
                    CFG_SPAN:         span_reg         <= cfg_data[SPAN_W-1:0];
                    CFG_SPAN_MODE:    span_mode_reg    <= cfg_data[0];
                    CFG_HOLD_MODE:    hold_mode_reg    <= cfg_data[0];
                    CFG_FEED_IN:      feed_in_reg      <= cfg_data[STAGE_SEL_W-1:0];
                    CFG_FEED_OUT:     feed_out_reg     <= cfg_data[STAGE_SEL_W-1:0];
                    CFG_FEED_MIX:     feed_mix_reg     <= cfg_data[MIX_W-1:0];
                    CFG_TAP_DIVIDERS: tap_dividers_reg <= cfg_data;
                    CFG_HOLD_CHANCES: hold_chances_reg <= cfg_data[MAX_TAPS*CHANCE_W-1:0];
                    default:          span_reg         <= span_reg;
                endcase
            end
        end
    end

    // Datapath helpers
    assign wp_inc   = (wp_reg == LAST_STAGE) ? '0 : wp_reg + 1'b1;
    assign stage_rd = rd_valid_reg ? $signed(ram_rd_data) : '0;
    assign old_val  = fi_zero_reg ? sample_reg : stage_rd;
    assign mix_sat  = (feed_mix_reg > MIX_W'(MIX_ONE)) ? MIX_W'(MIX_ONE) : feed_mix_reg;
    assign mix_inv  = MIX_W'(MIX_ONE) - mix_sat;
    assign mix_sum  = (W+11)'(prod_old_reg) + (W+11)'(prod_fb_reg);
    assign mix_shift = mix_sum >>> MIX_SHIFT;

    assign loc_start = span_mode_reg ?
                       ((span_red_reg == '0) ? LAST_STAGE : span_red_reg - 1'b1) : '0;
    assign loc_step  = span_mode_reg ? AW'(1) : span_red_reg;
    assign loc_sum   = {1'b0, loc_reg} + {1'b0, loc_step};
    assign loc_next  = (loc_sum >= N_EXT) ? AW'(loc_sum - N_EXT) : loc_sum[AW-1:0];

    assign tap_last    = (tap_idx_reg == TW'(NUM_TAPS - 1));
    assign tap_is_held = held_vec[tap_idx_reg];
    assign out_free    = !out_valid_reg || out_ready;

    // Next state, RAM accesses and strobes
    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wp_inc;
        ram_wr_data = sample_reg;
        ram_rd_en   = 1'b0;
        ram_rd_addr = stage_addr(wp_reg, fo_red_reg);
        take_item   = 1'b0;
        fb_cap      = 1'b0;
        mix_cap     = 1'b0;
        taps_init   = 1'b0;
        tap_load    = 1'b0;
        hold_ctl    = '{start: 1'b0, random: hold_mode_reg};

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take a sample and fetch the feedback source
                in_ready = !cfg_settle_reg;
                if (in_valid && !cfg_settle_reg)
                begin
                    take_item      = 1'b1;
                    ram_rd_en      = 1'b1;
                    hold_ctl.start = 1'b1;
                    state_next     = ST_FEED;
                end
            end
            ST_FEED:
            begin
                // Shift by writing the sample at the new head; fetch the target
                fb_cap      = 1'b1;
                ram_wr_en   = 1'b1;
                ram_rd_en   = 1'b1;
                ram_rd_addr = stage_addr(wp_inc, fi_red_reg);
                state_next  = ST_MIX;
            end
            ST_MIX:
            begin
                mix_cap    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // Write back the mixed target stage
                ram_wr_en   = 1'b1;
                ram_wr_addr = fi_addr_reg;
                ram_wr_data = mix_shift[W-1:0];
                taps_init   = 1'b1;
                state_next  = ST_TAP_RD;
            end
            ST_TAP_RD:
            begin
                ram_rd_addr = stage_addr(wp_reg, loc_reg);
                if (hold_done)
                begin
                    ram_rd_en  = 1'b1;
                    state_next = ST_TAP_OUT;
                end
            end
            ST_TAP_OUT:
            begin
                // Transfer one tap and prefetch the next
                ram_rd_addr = stage_addr(wp_reg, loc_next);
                if (out_free)
                begin
                    tap_load = 1'b1;
                    if (tap_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ram_rd_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            tick_reg      <= '0;
            tap_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                tap_vals_reg[t] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (ram_wr_en)
            begin
                valid_reg[ram_wr_addr] <= 1'b1;
            end
            if (ram_rd_en)
            begin
                rd_valid_reg <= valid_reg[ram_rd_addr];
            end
            if (fb_cap)
            begin
                wp_reg <= wp_inc;
            end
            if (taps_init)
            begin
                tap_idx_reg <= '0;
            end
            if (tap_load)
            begin
                if (!tap_is_held)
                begin
                    tap_vals_reg[tap_idx_reg] <= stage_rd;
                end
                if (tap_last)
                begin
                    tick_reg <= tick_reg + 1'b1;
                end
                else
                begin
                    tap_idx_reg <= tap_idx_reg + 1'b1;
                end
            end
            if (tap_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (take_item)
        begin
            sample_reg <= sample_in;
        end
        if (fb_cap)
        begin
            fb_reg      <= stage_rd;
            fi_addr_reg <= stage_addr(wp_inc, fi_red_reg);
            fi_zero_reg <= (fi_red_reg == '0);
        end
        if (mix_cap)
        begin
            prod_old_reg <= old_val * $signed({1'b0, mix_inv});
            prod_fb_reg  <= fb_reg * $signed({1'b0, mix_sat});
        end
        if (taps_init)
        begin
            loc_reg <= loc_start;
        end
        else if (tap_load)
        begin
            loc_reg <= loc_next;
        end
        if (tap_load)
        begin
            out_idx_reg   <= TAP_IDX_W'(tap_idx_reg);
            out_value_reg <= tap_is_held ? tap_vals_reg[tap_idx_reg] : stage_rd;
            out_held_reg  <= tap_is_held;
            out_last_reg  <= tap_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign tap_index = out_idx_reg;
    assign tap_value = $signed(out_value_reg);
    assign tap_held  = out_held_reg;
    assign last_tap  = out_last_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/tsrh_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tsrh_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then register the read word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/tsrh_hold.sv -----
// Per-tap hold decision: remainder lanes for dividers and random draws.
`default_nettype none

module tsrh_hold
    import tsrh_pkg::*;
#(
    parameter int NUM_TAPS = NUM_TAPS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire hold_ctl_t                    ctl,
    input  wire logic [TICK_W-1:0]            tick,
    input  wire logic [MAX_TAPS*DIV_W-1:0]    dividers,
    input  wire logic [MAX_TAPS*CHANCE_W-1:0] chances,
    output logic      [NUM_TAPS-1:0]          held,
    output logic                              done
);

    localparam int STEPS  = TICK_W / REM_BITS_PER_STEP;
    localparam int STEP_W = $clog2(STEPS);

    logic [TICK_W-1:0] rw_reg;
    logic [TICK_W-1:0] words [NUM_TAPS];
    logic              busy_reg;
    logic              done_reg;
    logic              random_reg;
    logic [STEP_W-1:0] step_reg;

    // Retire REM_BITS_PER_STEP dividend bits of one lane
    function automatic logic [DIV_W+TICK_W-1:0] rem_step(
        input logic [DIV_W-1:0]  rem,
        input logic [TICK_W-1:0] num,
        input logic [DIV_W-1:0]  den
    );
        logic [DIV_W:0]    r;
        logic [DIV_W-1:0]  rm;
        logic [TICK_W-1:0] nm;
        rm = rem;
        nm = num;
        for (int j = 0; j < REM_BITS_PER_STEP; j++)
        begin
            r  = {rm, nm[TICK_W-1]};
            nm = {nm[TICK_W-2:0], 1'b0};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
            end
            rm = r[DIV_W-1:0];
        end
        return {rm, nm};
    endfunction

    // Draw one LFSR word per tap, in tap order
    always_comb
    begin
        words[0] = lfsr_next(rw_reg);
        for (int t = 1; t < NUM_TAPS; t++)
        begin
            words[t] = lfsr_next(words[t-1]);
        end
    end

    // Sequence the lanes and advance the random word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rw_reg     <= LFSR_SEED;
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            random_reg <= 1'b0;
            step_reg   <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg   <= 1'b1;
            done_reg   <= 1'b0;
            random_reg <= ctl.random;
            step_reg   <= '0;
            if (ctl.random)
            begin
                rw_reg <= words[NUM_TAPS-1];
            end
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;

    // One remainder lane per tap
    for (genvar t = 0; t < NUM_TAPS; t++)
    begin : g_lane
        logic [TICK_W-1:0]       num_reg;
        logic [DIV_W-1:0]        den_reg;
        logic [DIV_W-1:0]        rem_reg;
        logic [DIV_W-1:0]        div_t;
        logic [CHANCE_W-1:0]     chance_t;
        logic [DIV_W+TICK_W-1:0] stepped;

        assign div_t    = dividers[t*DIV_W +: DIV_W];
        assign chance_t = chances[t*CHANCE_W +: CHANCE_W];
        assign stepped  = rem_step(rem_reg, num_reg, den_reg);

        // Load the dividend and divisor, then divide
        always_ff @(posedge clk)
        begin
            if (ctl.start)
            begin
                rem_reg <= '0;
                if (ctl.random)
                begin
                    num_reg <= words[t];
                    den_reg <= DIV_W'(HOLD_SCALE);
                end
                else
                begin
                    num_reg <= tick;
                    den_reg <= (div_t == '0) ? DIV_W'(1) : div_t;
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= stepped[DIV_W+TICK_W-1:TICK_W];
                num_reg <= stepped[TICK_W-1:0];
            end
        end

        // Hold on a nonzero phase, or on a draw below the chance
        assign held[t] = random_reg ? (rem_reg < {1'b0, chance_t}) : (rem_reg != '0);
    end

endmodule

`default_nettype wire

// ----- sim/tb_tapped_shift_register_with_holds.sv -----
// Self-checking testbench for the tapped shift register with per-tap holds.
`timescale 1ns / 1ps

module tb_tapped_shift_register_with_holds;
    import tsrh_pkg::*;

    localparam int STAGES = NUM_STAGES_DEF;
    localparam int TAPS   = NUM_TAPS_DEF;
    localparam int SW     = SAMPLE_WIDTH_DEF;

    // One tap result as seen on the output channel
    typedef struct {
        logic [TAP_IDX_W-1:0] index;
        logic signed [SW-1:0] value;
        logic                 held;
        logic                 last;
    } tap_result_t;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_ready;
    logic signed [SW-1:0]        sample_in = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [TAP_IDX_W-1:0]        tap_index;
    logic signed [SW-1:0]        tap_value;
    logic                        tap_held;
    logic                        last_tap;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;

    // Predicted register file
    logic [SPAN_W-1:0]             span_r;
    logic                          span_mode_r;
    logic                          hold_mode_r;
    logic [STAGE_SEL_W-1:0]        feed_in_r;
    logic [STAGE_SEL_W-1:0]        feed_out_r;
    logic [MIX_W-1:0]              feed_mix_r;
    logic [MAX_TAPS*DIV_W-1:0]     dividers_r;
    logic [MAX_TAPS*CHANCE_W-1:0]  chances_r;

    // Predicted datapath state
    logic signed [SW-1:0]  stage_mem [STAGES];
    logic signed [SW-1:0]  tap_mem [TAPS];
    logic [TICK_W-1:0]     tick_r;
    logic [TICK_W-1:0]     lfsr_r;

    tap_result_t pending_taps[$];

    int idle_pct  = 0;
    int stall_pct = 0;
    int n_samples = 0;
    int n_checked = 0;
    int n_errors  = 0;

    tapped_shift_register_with_holds i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample_in (sample_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .tap_held  (tap_held),
        .last_tap  (last_tap),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Stall the output side at random
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Shift one sample in, mix the feedback, update the taps and queue their results
    task automatic shift_and_tap(input logic signed [SW-1:0] s);
        int                   fi;
        int                   loc;
        int                   mix;
        int                   div;
        int                   chance;
        logic signed [SW-1:0] fb;
        longint               mixed;
        tap_result_t          r;
        begin
            fb  = stage_mem[feed_out_r % STAGES];
            fi  = feed_in_r % STAGES;
            mix = (feed_mix_r > MIX_ONE) ? MIX_ONE : int'(feed_mix_r);
            for (int k = STAGES - 1; k > 0; k--)
            begin
                stage_mem[k] = stage_mem[k-1];
            end
            stage_mem[0] = s;
            // Flooring shift of the weighted sum
            mixed = (longint'(stage_mem[fi]) * (MIX_ONE - mix) + longint'(fb) * mix)
                    >>> MIX_SHIFT;
            stage_mem[fi] = mixed[SW-1:0];

            for (int i = 0; i < TAPS; i++)
            begin
                if (span_mode_r == 1'b0)
                    loc = (i * int'(span_r)) % STAGES;
                else
                    loc = (i + int'(span_r) + STAGES - 1) % STAGES;

                if (hold_mode_r == 1'b0)
                begin
                    div = int'(dividers_r[DIV_W*i +: DIV_W]);
                    if (div == 0)
                        div = 1;
                    r.held = (int'(tick_r) % div) != 0;
                end
                else
                begin
                    lfsr_r = {lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5],
                              lfsr_r[TICK_W-1:1]};
                    chance = int'(chances_r[CHANCE_W*i +: CHANCE_W]);
                    r.held = (int'(lfsr_r) % HOLD_SCALE) < chance;
                end

                if (!r.held)
                    tap_mem[i] = stage_mem[loc];
                r.index = TAP_IDX_W'(i);
                r.value = tap_mem[i];
                r.last  = (i == TAPS - 1);
                pending_taps.push_back(r);
            end
            tick_r = tick_r + 1'b1;
        end
    endtask

    // Drop the input valid and wait for every queued tap result
    task automatic drain();
        begin
            if (in_valid)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            while (pending_taps.size() != 0)
                @(posedge clk);
        end
    endtask

    // Send one sample, idling first at random, and predict its taps on transfer
    task automatic send_sample(input logic signed [SW-1:0] s);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            @(negedge clk);
            in_valid  <= 1'b1;
            sample_in <= s;
            @(posedge clk);
            while (!in_ready)
                @(posedge clk);
            shift_and_tap(s);
            n_samples++;
        end
    endtask

    // Write one configuration register once the block has gone idle
    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
        begin
            drain();
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= data;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            case (idx)
                CFG_SPAN:         span_r      = data[SPAN_W-1:0];
                CFG_SPAN_MODE:    span_mode_r = data[0];
                CFG_HOLD_MODE:    hold_mode_r = data[0];
                CFG_FEED_IN:      feed_in_r   = data[STAGE_SEL_W-1:0];
                CFG_FEED_OUT:     feed_out_r  = data[STAGE_SEL_W-1:0];
                CFG_FEED_MIX:     feed_mix_r  = data[MIX_W-1:0];
                CFG_TAP_DIVIDERS: dividers_r  = data[MAX_TAPS*DIV_W-1:0];
                CFG_HOLD_CHANCES: chances_r   = data[MAX_TAPS*CHANCE_W-1:0];
            endcase
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    // Compare each tap transfer with the oldest prediction
    always @(posedge clk)
    begin : check_taps
        tap_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_taps.size() == 0)
            begin
                $error("tap result with nothing pending: index %0d value %0d",
                       tap_index, tap_value);
                n_errors++;
            end
            else
            begin
                want = pending_taps.pop_front();
                n_checked++;
                if (tap_index !== want.index)
                begin
                    $error("tap_index mismatch: expected %0d, got %0d", want.index, tap_index);
                    n_errors++;
                end
                if (tap_value !== want.value)
                begin
                    $error("tap_value mismatch: expected %0d, got %0d", want.value, tap_value);
                    n_errors++;
                end
                if (tap_held !== want.held)
                begin
                    $error("tap_held mismatch: expected %0b, got %0b", want.held, tap_held);
                    n_errors++;
                end
                if (last_tap !== want.last)
                begin
                    $error("last_tap mismatch: expected %0b, got %0b", want.last, last_tap);
                    n_errors++;
                end
            end
        end
    end

    // Reset settings with full-scale and near-zero samples
    task automatic test_reset_defaults();
        begin
            send_sample(16'sh7FFF);
            send_sample(16'sh8000);
            send_sample(16'sh0000);
            send_sample(-16'sd1);
        end
    endtask

    // Zero and largest span in both placement modes
    task automatic test_tap_placement();
        begin
            write_reg(CFG_SPAN, 64'd0);
            write_reg(CFG_SPAN_MODE, 64'd0);
            send_sample(16'sd1234);
            write_reg(CFG_SPAN_MODE, 64'd1);
            send_sample(-16'sd4321);
            write_reg(CFG_SPAN, 64'd255);
            write_reg(CFG_SPAN_MODE, 64'd0);
            send_sample(16'sh5555);
            write_reg(CFG_SPAN_MODE, 64'd1);
            send_sample(16'shAAAA);
        end
    endtask

    // Full feedback, saturated weight, same source and target, half mix on negatives
    task automatic test_feedback_mix();
        begin
            write_reg(CFG_FEED_IN, 64'd15);
            write_reg(CFG_FEED_OUT, 64'd0);
            write_reg(CFG_FEED_MIX, 64'd256);
            send_sample(16'sh7FFF);
            send_sample(16'sh8000);
            write_reg(CFG_FEED_IN, 64'd5);
            write_reg(CFG_FEED_OUT, 64'd5);
            write_reg(CFG_FEED_MIX, 64'd511);
            send_sample(-16'sd1);
            send_sample(16'sd12345);
            write_reg(CFG_FEED_IN, 64'd0);
            write_reg(CFG_FEED_OUT, 64'd3);
            write_reg(CFG_FEED_MIX, 64'd128);
            send_sample(-16'sd3);
            send_sample(16'sh8000);
        end
    endtask

    // Divider holds with zero, one, small and largest dividers
    task automatic test_divider_holds();
        begin
            write_reg(CFG_HOLD_MODE, 64'd0);
            write_reg(CFG_TAP_DIVIDERS, 64'h00FF_0302_0001_FF00);
            send_sample(-16'sd7);
            send_sample(16'sh7FFF);
            send_sample(16'sh8000);
        end
    endtask

    // Random holds with chances from never to always, above the scale too
    task automatic test_random_holds();
        begin
            write_reg(CFG_HOLD_CHANCES,
                      {8'hFF, 7'd0, 7'd64, 7'd1, 7'd50, 7'd99, 7'd127, 7'd100, 7'd0});
            write_reg(CFG_HOLD_MODE, 64'd1);
            send_sample(16'sd100);
            send_sample(-16'sd100);
            send_sample(16'sh4000);
        end
    endtask

    // Load a random setting into every register, extremes included
    task automatic randomize_config();
        logic [CFG_DATA_W-1:0] divs;
        logic [CFG_DATA_W-1:0] chs;
        logic [CFG_DATA_W-1:0] junk;
        begin
            junk = {$urandom, $urandom};
            case ($urandom_range(3))
                0:       write_reg(CFG_SPAN, {junk[63:8], 8'd0});
                1:       write_reg(CFG_SPAN, {junk[63:8], 8'd255});
                default: write_reg(CFG_SPAN, {junk[63:8], 8'($urandom)});
            endcase
            write_reg(CFG_SPAN_MODE, {$urandom, $urandom});
            write_reg(CFG_HOLD_MODE, {$urandom, $urandom});
            write_reg(CFG_FEED_IN, {$urandom, $urandom});
            write_reg(CFG_FEED_OUT, {$urandom, $urandom});
            case ($urandom_range(4))
                0:       write_reg(CFG_FEED_MIX, {junk[63:9], 9'd0});
                1:       write_reg(CFG_FEED_MIX, {junk[63:9], 9'd256});
                2:       write_reg(CFG_FEED_MIX, {junk[63:9], 9'($urandom_range(511, 257))});
                default: write_reg(CFG_FEED_MIX, {junk[63:9], 9'($urandom_range(255))});
            endcase
            chs = {$urandom, $urandom};
            for (int i = 0; i < TAPS; i++)
            begin
                divs[DIV_W*i +: DIV_W] = ($urandom_range(3) == 0) ? 8'($urandom)
                                                                  : 8'($urandom_range(4));
                chs[CHANCE_W*i +: CHANCE_W] = ($urandom_range(4) == 0)
                                              ? 7'($urandom) : 7'($urandom_range(100));
            end
            write_reg(CFG_TAP_DIVIDERS, divs);
            write_reg(CFG_HOLD_CHANCES, chs);
        end
    endtask

    // Random samples over several settings and idling patterns
    task automatic test_random_traffic();
        begin
            for (int phase = 0; phase < 8; phase++)
            begin
                case (phase % 4)
                    0: begin idle_pct = 0;  stall_pct = 0;  end
                    1: begin idle_pct = 61; stall_pct = 0;  end
                    2: begin idle_pct = 0;  stall_pct = 61; end
                    default: begin idle_pct = 34; stall_pct = 34; end
                endcase
                randomize_config();
                repeat (31)
                begin
                    send_sample(SW'($urandom));
                    // Hold off now and then until every tap has come out
                    if ($urandom_range(39) == 0)
                        drain();
                end
            end
        end
    endtask

    initial
    begin
        span_r      = SPAN_RST;
        span_mode_r = 1'b0;
        hold_mode_r = 1'b0;
        feed_in_r   = '0;
        feed_out_r  = FEED_OUT_RST;
        feed_mix_r  = '0;
        dividers_r  = TAP_DIVIDERS_RST;
        chances_r   = '0;
        for (int k = 0; k < STAGES; k++)
            stage_mem[k] = '0;
        for (int k = 0; k < TAPS; k++)
            tap_mem[k] = '0;
        tick_r = '0;
        lfsr_r = LFSR_SEED;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_tap_placement();
        test_feedback_mix();
        test_divider_holds();
        test_random_holds();
        test_random_traffic();

        // Let any stray transfer show up before the verdict
        drain();
        repeat (40) @(posedge clk);

        $display("Sent %0d samples: reset settings, tap placement, feedback mix, holds,",
                 n_samples);
        $display("random traffic under four idling patterns; %0d tap results checked, %0d mismatches",
                 n_checked, n_errors);
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
